/* hw/rtl/rpr_pkg.sv */
// ----------------------------------------------------------------------------
// rpr_pkg - shared types and constants for the palette register interface
// Access and result beats, queue commands, port codes and byte lane helpers.
// ----------------------------------------------------------------------------
package rpr_pkg;

	localparam int COLOR_ENTRIES   = 256;
	localparam int OVERLAY_ENTRIES = 4;
	localparam int PTR_W           = 10;
	localparam int ENT_W           = $clog2(COLOR_ENTRIES);
	localparam int COLOR_W         = 24;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

	// access kinds
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// port codes
	localparam logic [1:0] PORT_POINTER = 2'd0;
	localparam logic [1:0] PORT_PALETTE = 2'd1;
	localparam logic [1:0] PORT_CONTROL = 2'd2;
	localparam logic [1:0] PORT_OVERLAY = 2'd3;

	// byte lanes inside one entry
	localparam logic [1:0] LANE_RED   = 2'd0;
	localparam logic [1:0] LANE_GREEN = 2'd1;
	localparam logic [1:0] LANE_BLUE  = 2'd2;

	// control register 6 sits at slot 2 of registers 4..7
	localparam logic [1:0] CTRL_BLINK_SLOT = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [1:0] reg_addr;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       color_changed;
		logic [1:0] overlay_enable;
		logic [6:0] blink_on_frames;
		logic [6:0] blink_off_frames;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_DONE,
		CMD_PAL_READ,
		CMD_PAL_COMMIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ENT_W-1:0]   ent;
		logic [1:0]         lane;
		logic [COLOR_W-1:0] color;
		rsp_t               rsp;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_WAIT
	} back_state_t;

	typedef logic [ENT_W-1:0] ent_wrap_tbl_t [256];

	function automatic ent_wrap_tbl_t build_ent_wrap();
		ent_wrap_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = ENT_W'(i % COLOR_ENTRIES);
		end
		return t;
	endfunction

	// entry selected by a pointer write, indexed by the written byte
	localparam ent_wrap_tbl_t ENT_WRAP = build_ent_wrap();

	function automatic logic [7:0] get_lane(input logic [COLOR_W-1:0] color,
			input logic [1:0] lane);
		logic [7:0] b;
		case (lane)
			LANE_RED:   b = color[23:16];
			LANE_GREEN: b = color[15:8];
			LANE_BLUE:  b = color[7:0];
			default:    b = 8'd0;
		endcase
		return b;
	endfunction

	function automatic logic [COLOR_W-1:0] set_lane(input logic [COLOR_W-1:0] color,
			input logic [1:0] lane, input logic [7:0] v);
		logic [COLOR_W-1:0] c;
		c = color;
		case (lane)
			LANE_RED:   c[23:16] = v;
			LANE_GREEN: c[15:8]  = v;
			LANE_BLUE:  c[7:0]   = v;
			default:    c = color;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] blink_on_of(input logic [1:0] sel);
		logic [6:0] t;
		case (sel)
			2'd0:    t = 7'd16;
			2'd1:    t = 7'd16;
			2'd2:    t = 7'd32;
			default: t = 7'd64;
		endcase
		return t;
	endfunction

	function automatic logic [6:0] blink_off_of(input logic [1:0] sel);
		logic [6:0] t;
		case (sel)
			2'd0:    t = 7'd48;
			2'd1:    t = 7'd16;
			2'd2:    t = 7'd32;
			default: t = 7'd64;
		endcase
		return t;
	endfunction

endpackage

/* hw/rtl/rpr_front.sv */
// ----------------------------------------------------------------------------
// rpr_front - access decode and register state
// Walks the entry pointer, stages color bytes, holds control and overlay
// registers, and turns each access into a command for the palette side.
// ----------------------------------------------------------------------------
module rpr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  rpr_pkg::req_t req,
	output rpr_pkg::cmd_t cmd
);

	localparam logic [rpr_pkg::PTR_W:0] PAL_LIMIT =
		(rpr_pkg::PTR_W + 1)'(rpr_pkg::COLOR_ENTRIES * 4);
	localparam logic [rpr_pkg::PTR_W:0] OVL_LIMIT =
		(rpr_pkg::PTR_W + 1)'(rpr_pkg::OVERLAY_ENTRIES * 4);
	localparam logic [rpr_pkg::PTR_W-1:0] CTRL_LO = rpr_pkg::PTR_W'(4 * 4);
	localparam logic [rpr_pkg::PTR_W-1:0] CTRL_HI = rpr_pkg::PTR_W'(8 * 4);
	localparam logic [rpr_pkg::PTR_W-2:0] ENT_LIMIT =
		(rpr_pkg::PTR_W - 1)'(rpr_pkg::COLOR_ENTRIES);

	logic [rpr_pkg::PTR_W-1:0]   pointer_q, pointer_nxt;
	logic [rpr_pkg::COLOR_W-1:0] staging_q, staging_nxt;
	logic [rpr_pkg::COLOR_W-1:0] overlay_q [rpr_pkg::OVERLAY_ENTRIES];
	logic [rpr_pkg::COLOR_W-1:0] overlay_nxt [rpr_pkg::OVERLAY_ENTRIES];
	logic [7:0]                  ctrl_q [4];
	logic [7:0]                  ctrl_nxt [4];
	logic [1:0]                  mask_q, mask_nxt;
	logic [6:0]                  blink_on_q, blink_on_nxt;
	logic [6:0]                  blink_off_q, blink_off_nxt;

	logic [1:0]                  lane;
	logic [rpr_pkg::PTR_W-3:0]   ent;
	logic [rpr_pkg::COLOR_W-1:0] staged;
	logic                        is_write;
	logic [7:0]                  ctrl6;

	// advance one byte, skipping the unused fourth byte, and wrap at limit
	function automatic logic [rpr_pkg::PTR_W-1:0] ptr_step(
			input logic [rpr_pkg::PTR_W-1:0] p, input logic [rpr_pkg::PTR_W:0] limit);
		logic [rpr_pkg::PTR_W:0] s;
		s = {1'b0, p} + (rpr_pkg::PTR_W + 1)'(1);
		if (s[1:0] == 2'b11) begin
			s = s + (rpr_pkg::PTR_W + 1)'(1);
		end
		if (s >= limit) begin
			s = '0;
		end
		return s[rpr_pkg::PTR_W-1:0];
	endfunction

	assign lane     = pointer_q[1:0];
	assign ent      = pointer_q[rpr_pkg::PTR_W-1:2];
	assign is_write = (req.req_type == rpr_pkg::REQ_WRITE);
	assign staged   = rpr_pkg::set_lane(staging_q, lane, req.write_data);

	always_comb begin
		pointer_nxt   = pointer_q;
		staging_nxt   = staging_q;
		overlay_nxt   = overlay_q;
		ctrl_nxt      = ctrl_q;
		mask_nxt      = mask_q;
		blink_on_nxt  = blink_on_q;
		blink_off_nxt = blink_off_q;
		ctrl6         = ctrl_q[rpr_pkg::CTRL_BLINK_SLOT];

		cmd       = '0;
		cmd.kind  = rpr_pkg::CMD_DONE;
		cmd.ent   = ent[rpr_pkg::ENT_W-1:0];
		cmd.lane  = lane;
		cmd.color = staged;

		unique case (req.reg_addr)
			rpr_pkg::PORT_POINTER: begin
				if (is_write) begin
					pointer_nxt = rpr_pkg::PTR_W'({rpr_pkg::ENT_WRAP[req.write_data], 2'b00});
				end else begin
					cmd.rsp.read_data = ent[7:0];
				end
			end
			rpr_pkg::PORT_PALETTE: begin
				if (is_write) begin
					staging_nxt = staged;
					if (lane == rpr_pkg::LANE_BLUE && ent < ENT_LIMIT) begin
						cmd.kind = rpr_pkg::CMD_PAL_COMMIT;
					end
				end else if (ent < ENT_LIMIT) begin
					cmd.kind = rpr_pkg::CMD_PAL_READ;
				end
				pointer_nxt = ptr_step(pointer_q, PAL_LIMIT);
			end
			rpr_pkg::PORT_CONTROL: begin
				if (pointer_q >= CTRL_LO && pointer_q < CTRL_HI) begin
					if (is_write) begin
						ctrl_nxt[ent[1:0]] = req.write_data;
					end else begin
						cmd.rsp.read_data = ctrl_q[ent[1:0]];
					end
				end
				if (is_write) begin
					ctrl6         = ctrl_nxt[rpr_pkg::CTRL_BLINK_SLOT];
					mask_nxt      = ctrl6[1:0];
					blink_on_nxt  = rpr_pkg::blink_on_of(ctrl6[5:4]);
					blink_off_nxt = rpr_pkg::blink_off_of(ctrl6[5:4]);
				end
			end
			rpr_pkg::PORT_OVERLAY: begin
				if ({1'b0, pointer_q} < OVL_LIMIT) begin
					if (is_write) begin
						staging_nxt = staged;
						if (lane == rpr_pkg::LANE_BLUE) begin
							cmd.rsp.color_changed = (overlay_q[ent[1:0]] != staged);
							overlay_nxt[ent[1:0]] = staged;
						end
					end else begin
						cmd.rsp.read_data = rpr_pkg::get_lane(overlay_q[ent[1:0]], lane);
					end
					pointer_nxt = ptr_step(pointer_q, OVL_LIMIT);
				end
			end
		endcase

		cmd.rsp.overlay_enable   = mask_nxt;
		cmd.rsp.blink_on_frames  = blink_on_nxt;
		cmd.rsp.blink_off_frames = blink_off_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_q   <= '0;
			staging_q   <= '0;
			mask_q      <= '0;
			blink_on_q  <= '0;
			blink_off_q <= '0;
			for (int i = 0; i < rpr_pkg::OVERLAY_ENTRIES; i++) begin
				overlay_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				ctrl_q[i] <= '0;
			end
		end else if (accept) begin
			pointer_q   <= pointer_nxt;
			staging_q   <= staging_nxt;
			overlay_q   <= overlay_nxt;
			ctrl_q      <= ctrl_nxt;
			mask_q      <= mask_nxt;
			blink_on_q  <= blink_on_nxt;
			blink_off_q <= blink_off_nxt;
		end
	end

`ifndef SYNTHESIS
	// a palette command always names an entry inside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind != rpr_pkg::CMD_DONE) |-> (ent < ENT_LIMIT))
		else $error("palette command outside the color table");
`endif

endmodule

/* hw/rtl/rpr_queue.sv */
// ----------------------------------------------------------------------------
// rpr_queue - short command queue
// Decouples access decode from the palette memory side.
// ----------------------------------------------------------------------------
module rpr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rpr_pkg::cmd_t din,
	input  logic          pop,
	output rpr_pkg::cmd_t dout,
	output logic          full,
	output logic          empty
);

	rpr_pkg::cmd_t               slot_q [rpr_pkg::QUEUE_DEPTH];
	logic [rpr_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [rpr_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [rpr_pkg::QUEUE_AW:0]   count_q;

	localparam logic [rpr_pkg::QUEUE_AW-1:0] LAST_SLOT =
		rpr_pkg::QUEUE_AW'(rpr_pkg::QUEUE_DEPTH - 1);
	localparam logic [rpr_pkg::QUEUE_AW:0] FULL_COUNT =
		(rpr_pkg::QUEUE_AW + 1)'(rpr_pkg::QUEUE_DEPTH);
	localparam logic [rpr_pkg::QUEUE_AW:0] COUNT_ONE =
		(rpr_pkg::QUEUE_AW + 1)'(1);

	assign full  = (count_q == FULL_COUNT);
	assign empty = (count_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + COUNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - COUNT_ONE;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("command queue underflow");
`endif

endmodule

/* hw/rtl/rpr_back.sv */
// ----------------------------------------------------------------------------
// rpr_back - palette memory side
// Reads and commits color table entries and drives the result register.
// ----------------------------------------------------------------------------
module rpr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rpr_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rpr_pkg::rsp_t rsp
);

	rpr_pkg::back_state_t        state_q, state_nxt;
	rpr_pkg::cmd_t               cmd_q;
	rpr_pkg::rsp_t               rsp_q, rsp_nxt;
	logic                        rsp_valid_q;
	logic                        load_out;
	logic                        mem_re;
	logic                        mem_we;
	logic [rpr_pkg::COLOR_W-1:0] mem_q [rpr_pkg::COLOR_ENTRIES];
	logic [rpr_pkg::COLOR_W-1:0] rd_data_q;
	logic                        rd_valid_q;
	logic [rpr_pkg::COLOR_ENTRIES-1:0] valid_q;
	logic [rpr_pkg::COLOR_W-1:0] entry;
	logic                        out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	// never-written entries read as zero
	assign entry     = rd_valid_q ? rd_data_q : '0;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rpr_pkg::BK_IDLE: begin
				if (!empty && out_free && head.kind != rpr_pkg::CMD_DONE) begin
					state_nxt = rpr_pkg::BK_WAIT;
				end
			end
			rpr_pkg::BK_WAIT: state_nxt = rpr_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		load_out = 1'b0;
		rsp_nxt  = head.rsp;
		unique case (state_q)
			rpr_pkg::BK_IDLE: begin
				pop = !empty && out_free;
				if (pop) begin
					if (head.kind == rpr_pkg::CMD_DONE) begin
						load_out = 1'b1;
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			rpr_pkg::BK_WAIT: begin
				load_out = 1'b1;
				rsp_nxt  = cmd_q.rsp;
				if (cmd_q.kind == rpr_pkg::CMD_PAL_READ) begin
					rsp_nxt.read_data = rpr_pkg::get_lane(entry, cmd_q.lane);
				end
				if (cmd_q.kind == rpr_pkg::CMD_PAL_COMMIT) begin
					mem_we                = 1'b1;
					rsp_nxt.color_changed = (entry != cmd_q.color);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[cmd_q.ent] <= cmd_q.color;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[head.ent];
			cmd_q     <= head;
		end
		if (load_out) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpr_pkg::BK_IDLE;
			rsp_valid_q <= 1'b0;
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (mem_re) begin
				rd_valid_q <= valid_q[head.ent];
			end
			if (mem_we) begin
				valid_q[cmd_q.ent] <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// the result register was drained when the lookup started
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpr_pkg::BK_WAIT) |-> !rsp_valid_q)
		else $error("result register busy during palette lookup");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpr_pkg::BK_WAIT) |=> rsp_valid_q)
		else $error("palette lookup produced no result");
`endif

endmodule

/* hw/rtl/ramdac_palette_registers.sv */
// A pointer, control, overlay or staging-only palette access goes through the
// queue slot and result register, a palette read or commit also through the
// table read register. Throughput: one beat per cycle when not stalled; a read
// or commit (read, then write) holds the back end waiting, popping nothing.
// Reset clears the pointer, staging, control, overlay colors and the table's
// per-entry valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ramdac_palette_registers - palette RAMDAC register interface
// Decode front, two-entry command queue, and color table back end.
// ----------------------------------------------------------------------------
module ramdac_palette_registers (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rpr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rpr_pkg::rsp_t rsp
);

	logic          accept;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	rpr_pkg::cmd_t front_cmd;
	rpr_pkg::cmd_t q_head;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	rpr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.cmd    (front_cmd)
	);

	rpr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (front_cmd),
		.pop    (q_pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	rpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
